### sv/multiply_format_grouped_decimal_defines.svh
// Assertion macros shared by the multiply and format block.
`ifndef MULTIPLY_FORMAT_GROUPED_DECIMAL_DEFINES_SVH
`define MULTIPLY_FORMAT_GROUPED_DECIMAL_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MFGD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MFGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### sv/mfgd_pkg.sv
// Package: constants and helpers for the multiply and grouped decimal formatter.
package mfgd_pkg;

  localparam int OPER_W     = 64;
  localparam int MAX_DIGITS = 20;
  localparam int BCD_W      = 4 * MAX_DIGITS;
  localparam int GROUP_SIZE = 3;
  // Digit count modulo group size at the start of the leading-zero scan
  localparam int GRP_INIT   = MAX_DIGITS % GROUP_SIZE;

  localparam logic [7:0] SEP_CHAR   = 8'h27;
  localparam logic [7:0] MINUS_CHAR = 8'h2d;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] OVF_CHAR   = 8'h00;

  // Double-dabble correction: add 3 to a BCD digit of 5 or more
  function automatic logic [3:0] add3(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? (d + 4'd3) : d;
    return r;
  endfunction

endpackage

### sv/mfgd_bcd_conv.sv
// Iterative binary to BCD converter: one shift-add-3 step per cycle.
module mfgd_bcd_conv
  import mfgd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [OPER_W-1:0]  value,
  output logic               done,
  output logic [BCD_W-1:0]   bcd
);

  logic                      running;
  logic [5:0]                cnt;
  logic [OPER_W-1:0]         bin;
  logic [BCD_W-1:0]          corr;

  // Per-digit correction ahead of the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      corr[4*i +: 4] = add3(bcd[4*i +: 4]);
    end
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(OPER_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Shift datapath
  always_ff @(posedge clk) begin
    if (load) begin
      bin <= value;
      bcd <= '0;
    end else if (running) begin
      bcd <= {corr[BCD_W-2:0], bin[OPER_W-1]};
      bin <= {bin[OPER_W-2:0], 1'b0};
    end
  end

endmodule

### sv/multiply_format_grouped_decimal.sv
// Top level: signed 64x64 multiply with grouped decimal ASCII output.
//
// Pulse start while busy is low to begin a transaction with multiplicand and
// multiplier. The magnitudes are multiplied by a shift-add unit, one bit per
// cycle, then the S_CHECK state checks the product against the signed
// 64-bit range. An out-of-range product gives a single result with overflow,
// last and character 0. Otherwise a double-dabble converter converts the
// product, a leading-zero scan drops leading zeros but keeps one digit, and the
// text follows one character per cycle: an optional '-', the digits, and an
// apostrophe between groups of three digits counted from the right, up to
// 26 characters. Each character is shown for exactly one cycle with strobe
// high and cannot be stalled; last marks the final character. busy drops in
// the cycle that the final character is shown, so the next start may be
// accepted then.
module multiply_format_grouped_decimal
  import mfgd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [OPER_W-1:0]  multiplicand,
  input  logic signed [OPER_W-1:0]  multiplier,
  output logic                      strobe,
  output logic [7:0]                character,
  output logic                      last,
  output logic                      overflow
);

`include "multiply_format_grouped_decimal_defines.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_CONV  = 4'd3;
  localparam logic [3:0] S_SKIP  = 4'd4;
  localparam logic [3:0] S_SIGN  = 4'd5;
  localparam logic [3:0] S_SEP   = 4'd6;
  localparam logic [3:0] S_DIGIT = 4'd7;

  logic [3:0]          state;
  logic [5:0]          cnt;
  logic [OPER_W-1:0]   mcand;
  logic [OPER_W-1:0]   hi;
  logic [OPER_W-1:0]   lo;
  logic                neg;
  logic [BCD_W-1:0]    digits;
  logic [4:0]          rem;
  logic [1:0]          grp;

  logic                accept;
  logic [OPER_W-1:0]   mag_a;
  logic [OPER_W-1:0]   mag_b;
  logic [OPER_W:0]     sum;
  logic                prod_zero;
  logic                neg_eff;
  logic [OPER_W-1:0]   limit;
  logic                ovf;
  logic                conv_load;
  logic                conv_done;
  logic [BCD_W-1:0]    conv_bcd;
  logic [3:0]          top_digit;
  logic [1:0]          grp_dec;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Operand magnitudes
  assign mag_a = multiplicand[OPER_W-1] ? (~multiplicand + 64'd1) : multiplicand;
  assign mag_b = multiplier[OPER_W-1]   ? (~multiplier + 64'd1)   : multiplier;

  // Shift-add step
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : {(OPER_W+1){1'b0}});

  // Range check on the finished product
  assign prod_zero = (hi == '0) && (lo == '0);
  assign neg_eff   = neg && !prod_zero;
  assign limit     = neg_eff ? {1'b1, {(OPER_W-1){1'b0}}} : {1'b0, {(OPER_W-1){1'b1}}};
  assign ovf       = (hi != '0) || (lo > limit);
  assign conv_load = (state == S_CHECK) && !ovf;

  // Digit emission helpers
  assign top_digit = digits[BCD_W-1 -: 4];
  assign grp_dec   = (grp == 2'd0) ? 2'(GROUP_SIZE - 1) : (grp - 2'd1);

  mfgd_bcd_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .load  (conv_load),
    .value (lo),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      cnt    <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mcand <= mag_a;
            hi    <= '0;
            lo    <= mag_b;
            neg   <= multiplicand[OPER_W-1] ^ multiplier[OPER_W-1];
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          hi  <= sum[OPER_W:1];
          lo  <= {sum[0], lo[OPER_W-1:1]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(OPER_W - 1)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          neg <= neg_eff;
          if (ovf) begin
            strobe    <= 1'b1;
            character <= OVF_CHAR;
            last      <= 1'b1;
            overflow  <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (conv_done) begin
            digits <= conv_bcd;
            rem    <= 5'(MAX_DIGITS);
            grp    <= 2'(GRP_INIT);
            state  <= S_SKIP;
          end
        end
        S_SKIP: begin
          // Drop leading zeros, keep at least one digit
          if ((rem > 5'd1) && (top_digit == 4'd0)) begin
            digits <= {digits[BCD_W-5:0], 4'd0};
            rem    <= rem - 5'd1;
            grp    <= grp_dec;
          end else begin
            state <= neg ? S_SIGN : S_DIGIT;
          end
        end
        S_SIGN: begin
          strobe    <= 1'b1;
          character <= MINUS_CHAR;
          last      <= 1'b0;
          overflow  <= 1'b0;
          state     <= S_DIGIT;
        end
        S_SEP: begin
          strobe    <= 1'b1;
          character <= SEP_CHAR;
          last      <= 1'b0;
          overflow  <= 1'b0;
          state     <= S_DIGIT;
        end
        S_DIGIT: begin
          strobe    <= 1'b1;
          character <= ZERO_CHAR + {4'd0, top_digit};
          last      <= (rem == 5'd1);
          overflow  <= 1'b0;
          digits    <= {digits[BCD_W-5:0], 4'd0};
          rem       <= rem - 5'd1;
          grp       <= grp_dec;
          if (rem == 5'd1) begin
            state <= S_IDLE;
          end else if (grp_dec == 2'd0) begin
            state <= S_SEP;
          end else begin
            state <= S_DIGIT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `MFGD_ASSERT_IMP(a_ovf_sole, clk, rst, strobe && overflow, last && (character == OVF_CHAR))
  `MFGD_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `MFGD_ASSERT_NEXT(a_text_contiguous, clk, rst, strobe && !last, strobe)
  `MFGD_ASSERT_IMP(a_busy_mid_text, clk, rst, strobe && !last, busy)

endmodule
